// ===== hdl/tbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpr_pkg
// shared constants, codes and types of the tile background pixel renderer
// ----------------------------------------------------------------------------
`default_nettype none

package tbpr_pkg;

    localparam int MAP_WIDTH_DEF     = 32;
    localparam int MAP_HEIGHT_DEF    = 32;
    localparam int TILE_COUNT_DEF    = 1024;
    localparam int SCREEN_WIDTH_DEF  = 160;
    localparam int SCREEN_HEIGHT_DEF = 144;

    localparam int REMAP_DEPTH    = 1024;
    localparam int BYTES_PER_TILE = 16;

    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 14;
    localparam int VALUE_W = 10;
    localparam int COORD_W = 8;
    localparam int SHADE_W = 8;
    localparam int CI_W    = 2;
    localparam int PAL_W   = 8;

    localparam logic [PAL_W-1:0] PALETTE_RESET = 8'hE4;

    typedef enum logic [KIND_W-1:0] {
        KIND_MAP    = 2'd0,
        KIND_REMAP  = 2'd1,
        KIND_PIXELS = 2'd2,
        KIND_RENDER = 2'd3
    } t_kind;

    typedef struct packed {
        logic            load;
        logic            tile_ok;
        logic [1:0]      lane;
    } t_pix_load;

    function automatic logic [SHADE_W-1:0] shade_of(input logic [1:0] sel);
        logic [SHADE_W-1:0] s;
        case (sel)
            2'd0:    s = 8'd255;
            2'd1:    s = 8'd170;
            2'd2:    s = 8'd85;
            2'd3:    s = 8'd0;
            default: s = 8'd255;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tbpr_channels.sv =====
// ----------------------------------------------------------------------------
// tbpr channels
// valid/ready channels for requests, results and the palette register
// ----------------------------------------------------------------------------
`default_nettype none

interface tbpr_req_if import tbpr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (output valid, kind, address, value, pixel_x, pixel_y, input ready);
    modport sink   (input valid, kind, address, value, pixel_x, pixel_y, output ready);
endinterface

interface tbpr_res_if import tbpr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SHADE_W-1:0] shade;
    logic [CI_W-1:0]    pix_code;

    modport source (output valid, shade, pix_code, input ready);
    modport sink   (input valid, shade, pix_code, output ready);
endinterface

interface tbpr_cfg_if import tbpr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PAL_W-1:0] palette;

    modport source (output valid, palette, input ready);
    modport sink   (input valid, palette, output ready);
endinterface

`default_nettype wire

// ===== hdl/tbpr_ram.sv =====
// ----------------------------------------------------------------------------
// tbpr_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/tbpr_shade.sv =====
// ----------------------------------------------------------------------------
// tbpr_shade
// picks the color index from the fetched tile byte, maps it through the
// palette and holds the result until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_shade import tbpr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_pix_load        i_ld,
    input  wire logic [7:0]       i_pix_byte,
    input  wire logic [PAL_W-1:0] i_palette,
    output logic                  o_full,
    tbpr_res_if.source            o_res
);

    logic               r_valid;
    logic               n_valid;
    logic [SHADE_W-1:0] r_shade;
    logic [CI_W-1:0]    r_ci;
    logic [CI_W-1:0]    ci;
    logic [1:0]         sel;

    always_comb begin
        ci  = i_ld.tile_ok ? i_pix_byte[{i_ld.lane, 1'b0} +: CI_W] : '0;
        sel = i_palette[{ci, 1'b0} +: 2];
    end

    always_comb begin
        n_valid = r_valid;
        if (o_res.ready) begin
            n_valid = 1'b0;
        end
        if (i_ld.load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_ld.load) begin
            r_shade <= shade_of(sel);
            r_ci    <= ci;
        end
    end

    assign o_full         = r_valid && !o_res.ready;
    assign o_res.valid    = r_valid;
    assign o_res.shade    = r_shade;
    assign o_res.pix_code = r_ci;

    // a new pixel never overwrites one the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ld.load |-> !(r_valid && !o_res.ready))
        else $error("pixel loaded over a pending result");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=>
            o_res.valid && $stable(o_res.shade) && $stable(o_res.pix_code))
        else $error("stalled result changed");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ld.load |=> o_res.valid)
        else $error("loaded pixel not presented");

endmodule

`default_nettype wire

// ===== hdl/tile_background_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer
// tile map background generator, 2 bits per pixel, gray shades
// ----------------------------------------------------------------------------
// i_req carries one item per transaction: kind selects a tile map write, a
// remap write, a packed tile byte write (four pixels, lowest bits first) or
// a pixel render at pixel_x, pixel_y. o_res returns shade and pix_code
// for each on-screen render; writes and off-screen renders return nothing.
// i_cfg writes the background palette; it is always ready and is meant to
// be written while no render is in flight.
// A write or an off-screen render leaves the state machine in S_IDLE. An
// on-screen render walks three dependent memory reads (tile map, remap
// table, tile bytes) through S_REMAP, S_PIX and S_DONE; its result is then
// registered in the output register, and i_req is ready again from S_IDLE.
// After reset the tile map is cleared to tile zero, one entry a cycle, over
// all MAP_WIDTH*MAP_HEIGHT entries (1024 by default) while i_req stays not
// ready; the palette returns to 0xE4. A stalled result is held in the
// output register; a finished render waits in S_DONE until the sink takes the
// earlier result, and i_req stays not ready meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_background_pixel_renderer import tbpr_pkg::*; #(
    parameter int MAP_WIDTH     = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT    = MAP_HEIGHT_DEF,
    parameter int TILE_COUNT    = TILE_COUNT_DEF,
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tbpr_req_if.sink   i_req,
    tbpr_cfg_if.sink   i_cfg,
    tbpr_res_if.source o_res
);

    localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int REMAP_AW  = $clog2(REMAP_DEPTH);
    localparam int TILE_W    = $clog2(TILE_COUNT);
    localparam int PIX_DEPTH = TILE_COUNT * BYTES_PER_TILE;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_REMAP = 5'b00100,
        S_PIX   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [MAP_AW-1:0]  r_clr_addr;
    logic [MAP_AW-1:0]  n_clr_addr;
    logic [PAL_W-1:0]   r_palette;
    logic [2:0]         r_px_lo;
    logic [2:0]         r_py_lo;
    logic               r_tile_ok;
    logic               n_tile_ok;

    logic               accept;
    logic               onscreen;
    logic [6:0]         col;
    logic [6:0]         row;
    logic [MAP_AW-1:0]  map_raddr;

    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr;
    logic [VALUE_W-1:0] map_wdata;
    logic               map_re;
    logic [VALUE_W-1:0] map_rdata;

    logic               remap_we;
    logic               remap_re;
    logic [VALUE_W-1:0] remap_rdata;

    logic               pix_we;
    logic               pix_re;
    logic [PIX_AW-1:0]  pix_raddr;
    logic [7:0]         pix_rdata;

    t_pix_load          ld;
    logic               shade_full;

    assign accept       = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    // tile column and row wrap around the map, at most one wrap each
    always_comb begin
        col = {2'b00, i_req.pixel_x[COORD_W-1:3]};
        row = {2'b00, i_req.pixel_y[COORD_W-1:3]};
        if (col >= 7'(MAP_WIDTH)) begin
            col = col - 7'(MAP_WIDTH);
        end
        if (row >= 7'(MAP_HEIGHT)) begin
            row = row - 7'(MAP_HEIGHT);
        end
        map_raddr = MAP_AW'(col) + MAP_AW'(32'(row) * MAP_WIDTH);
        onscreen  = ({2'b00, i_req.pixel_x} < 10'(SCREEN_WIDTH))
                 && ({2'b00, i_req.pixel_y} < 10'(SCREEN_HEIGHT));
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_tile_ok  = r_tile_ok;
        map_we     = 1'b0;
        map_waddr  = MAP_AW'(i_req.address);
        map_wdata  = i_req.value;
        map_re     = 1'b0;
        remap_we   = 1'b0;
        remap_re   = 1'b0;
        pix_we     = 1'b0;
        pix_re     = 1'b0;
        ld         = '{load: 1'b0, tile_ok: r_tile_ok, lane: r_px_lo[1:0]};
        case (r_state)
            S_CLEAR: begin
                map_we     = 1'b1;
                map_waddr  = r_clr_addr;
                map_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_req.kind))
                        KIND_MAP: begin
                            map_we = (32'(i_req.address) < MAP_DEPTH);
                        end
                        KIND_REMAP: begin
                            remap_we = (32'(i_req.address) < REMAP_DEPTH);
                        end
                        KIND_PIXELS: begin
                            pix_we = (32'(i_req.address) < PIX_DEPTH);
                        end
                        KIND_RENDER: begin
                            if (onscreen) begin
                                map_re  = 1'b1;
                                n_state = S_REMAP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REMAP: begin
                remap_re = 1'b1;
                n_state  = S_PIX;
            end
            S_PIX: begin
                pix_re    = 1'b1;
                n_tile_ok = (32'(remap_rdata) < TILE_COUNT);
                n_state   = S_DONE;
            end
            S_DONE: begin
                ld.load = !shade_full;
                if (!shade_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign pix_raddr = {TILE_W'(remap_rdata), r_py_lo, r_px_lo[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_palette  <= PALETTE_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg.valid && i_cfg.ready) begin
                r_palette <= i_cfg.palette;
            end
        end
        r_tile_ok <= n_tile_ok;
        if (accept) begin
            r_px_lo <= i_req.pixel_x[2:0];
            r_py_lo <= i_req.pixel_y[2:0];
        end
    end

    tbpr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    tbpr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (REMAP_DEPTH)
    ) u_remap_ram (
        .i_clk   (i_clk),
        .i_we    (remap_we),
        .i_waddr (i_req.address[REMAP_AW-1:0]),
        .i_wdata (i_req.value),
        .i_re    (remap_re),
        .i_raddr (map_rdata[REMAP_AW-1:0]),
        .o_rdata (remap_rdata)
    );

    tbpr_ram #(
        .WIDTH (8),
        .DEPTH (PIX_DEPTH)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (PIX_AW'(i_req.address)),
        .i_wdata (i_req.value[7:0]),
        .i_re    (pix_re),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    tbpr_shade u_shade (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld       (ld),
        .i_pix_byte (pix_rdata),
        .i_palette  (r_palette),
        .o_full     (shade_full),
        .o_res      (o_res)
    );

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && (r_clr_addr == CLR_LAST) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end at the last map entry");

    a_render_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.kind == KIND_RENDER) && onscreen |=> (r_state == S_REMAP))
        else $error("on-screen render did not start the fetch");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished render");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the tile background pixel renderer
// ----------------------------------------------------------------------------
// Mirrors the tile map, the remap table, the tile pixels and the palette.
// Each accepted request updates the mirror, and each on-screen render
// queues the shade and color index it should produce. Every result
// transaction is checked against the oldest queued one. Renders are
// preceded by the writes they need, so no unwritten remap entry or pixel is read.
// Directed tests cover store limits, off-screen pixels and palette
// extremes. Random traffic then runs under three idle patterns.
// ----------------------------------------------------------------------------

module tb_top;
    import tbpr_pkg::*;

    localparam int MAP_DEPTH    = MAP_WIDTH_DEF * MAP_HEIGHT_DEF;
    localparam int PIXEL_DEPTH  = TILE_COUNT_DEF * 64;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 500000;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  address;
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_pixel_req;

    typedef struct packed {
        logic [SHADE_W-1:0] shade;
        logic [CI_W-1:0]    pix_code;
    } t_pixel_out;

    logic clk = 1'b0;
    logic rst_n;

    tbpr_req_if req_if ();
    tbpr_res_if res_if ();
    tbpr_cfg_if cfg_if ();

    tile_background_pixel_renderer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    bit [VALUE_W-1:0] map_mirror   [MAP_DEPTH];
    bit [VALUE_W-1:0] remap_mirror [REMAP_DEPTH];
    bit               remap_set    [REMAP_DEPTH];
    bit [1:0]         pixel_mirror [PIXEL_DEPTH];
    bit               pixel_set    [PIXEL_DEPTH];
    bit [PAL_W-1:0]   palette_mirror;

    t_pixel_out shade_queue [$];
    t_pixel_out want;
    int         fail_count  = 0;
    int         cycle_count = 0;
    int         item_count  = 0;
    int         src_idle_pct;
    int         snk_idle_pct;

    always #5 clk = ~clk;

    // updates the mirror for one accepted request; returns 1 if a result is due
    function automatic bit predict_pixel(input t_pixel_req r, output t_pixel_out o);
        int base;
        int k;
        int tno;
        int tile;
        int off;
        int ci;
        int sel;
        o = '0;
        predict_pixel = 1'b0;
        case (r.kind)
            KIND_MAP: begin
                if (int'(r.address) < MAP_DEPTH)
                    map_mirror[int'(r.address)] = r.value;
            end
            KIND_REMAP: begin
                if (int'(r.address) < REMAP_DEPTH) begin
                    remap_mirror[int'(r.address)] = r.value;
                    remap_set[int'(r.address)]    = 1'b1;
                end
            end
            KIND_PIXELS: begin
                base = int'(r.address) * 4;
                if (base + 3 < PIXEL_DEPTH) begin
                    for (k = 0; k < 4; k++) begin
                        pixel_mirror[base + k] = r.value[2*k +: 2];
                        pixel_set[base + k]    = 1'b1;
                    end
                end
            end
            KIND_RENDER: begin
                if (int'(r.pixel_x) < SCREEN_WIDTH_DEF && int'(r.pixel_y) < SCREEN_HEIGHT_DEF) begin
                    tno  = int'(map_mirror[((int'(r.pixel_x) / 8) % MAP_WIDTH_DEF)
                                + ((int'(r.pixel_y) / 8) % MAP_HEIGHT_DEF) * MAP_WIDTH_DEF]);
                    tile = int'(remap_mirror[tno]);
                    ci   = 0;
                    if (tile < TILE_COUNT_DEF) begin
                        off = (int'(r.pixel_x) % 8) + (int'(r.pixel_y) % 8) * 8;
                        ci  = int'(pixel_mirror[tile * 64 + off]);
                    end
                    sel           = int'(palette_mirror >> (2 * ci)) & 3;
                    o.shade       = SHADE_W'(255 - sel * 85);
                    o.pix_code    = CI_W'(ci);
                    predict_pixel = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_pixel_req rand_req(input t_kind k);
        t_pixel_req r;
        r.kind    = k;
        r.address = ADDR_W'($urandom);
        r.value   = VALUE_W'($urandom);
        r.pixel_x = COORD_W'($urandom);
        r.pixel_y = COORD_W'($urandom);
        return r;
    endfunction

    // mostly a few tiles so that written tiles get reused
    function automatic logic [VALUE_W-1:0] pick_tile();
        if ($urandom_range(3) == 0)
            return VALUE_W'($urandom_range(TILE_COUNT_DEF - 1));
        return VALUE_W'($urandom_range(15));
    endfunction

    task automatic send_item(input t_pixel_req r);
        t_pixel_out o;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.kind    <= r.kind;
        req_if.address <= r.address;
        req_if.value   <= r.value;
        req_if.pixel_x <= r.pixel_x;
        req_if.pixel_y <= r.pixel_y;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        item_count++;
        if (predict_pixel(r, o))
            shade_queue.push_back(o);
    endtask

    task automatic write_item(input t_kind k, input int addr, input int val);
        t_pixel_req r;
        r         = rand_req(k);
        r.address = ADDR_W'(addr);
        r.value   = VALUE_W'(val);
        send_item(r);
    endtask

    // writes whatever remap entry and tile byte the pixel needs, then renders
    task automatic render_pixel(input int x, input int y);
        t_pixel_req r;
        int         tno;
        int         tile;
        int         pix;
        if (x < SCREEN_WIDTH_DEF && y < SCREEN_HEIGHT_DEF) begin
            tno = int'(map_mirror[((x / 8) % MAP_WIDTH_DEF)
                       + ((y / 8) % MAP_HEIGHT_DEF) * MAP_WIDTH_DEF]);
            if (!remap_set[tno])
                write_item(KIND_REMAP, tno, int'(pick_tile()));
            tile = int'(remap_mirror[tno]);
            pix  = tile * 64 + (x % 8) + (y % 8) * 8;
            if (tile < TILE_COUNT_DEF && !pixel_set[pix])
                write_item(KIND_PIXELS, pix / 4, int'($urandom_range(1023)));
        end
        r         = rand_req(KIND_RENDER);
        r.pixel_x = COORD_W'(x);
        r.pixel_y = COORD_W'(y);
        send_item(r);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (shade_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_palette(input logic [PAL_W-1:0] pal);
        wait_idle();
        cfg_if.valid   <= 1'b1;
        cfg_if.palette <= pal;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        palette_mirror = pal;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_palette();
        render_pixel(0, 0);
        render_pixel(7, 7);
    endtask

    task automatic test_store_limits();
        write_item(KIND_MAP, 0, 5);
        write_item(KIND_MAP, MAP_DEPTH - 1, 1023);
        write_item(KIND_MAP, MAP_DEPTH, 7);
        write_item(KIND_MAP, 16383, 9);
        write_item(KIND_REMAP, 5, 1023);
        write_item(KIND_REMAP, REMAP_DEPTH, 3);
        write_item(KIND_REMAP, 16383, 4);
        // bits 9..8 set and ignored, pixels 0 to 3 of the last tile
        write_item(KIND_PIXELS, (TILE_COUNT_DEF - 1) * 16, 'h3E4);
        write_item(KIND_PIXELS, 16383, 'h01B);
        for (int x = 0; x < 4; x++)
            render_pixel(x, 0);
        render_pixel(SCREEN_WIDTH_DEF - 1, SCREEN_HEIGHT_DEF - 1);
        render_pixel(SCREEN_WIDTH_DEF, 0);
        render_pixel(0, SCREEN_HEIGHT_DEF);
        render_pixel(255, 255);
    endtask

    task automatic test_palette_extremes();
        write_palette(8'h00);
        for (int x = 0; x < 4; x++)
            render_pixel(x, 0);
        write_palette(8'hFF);
        for (int x = 0; x < 4; x++)
            render_pixel(x, 0);
    endtask

    // sends n_items transactions, the writes a render needs included
    task automatic test_random_traffic(input int n_items, input int src_pct,
                                       input int snk_pct, input logic [PAL_W-1:0] pal);
        int choice;
        int addr;
        int val;
        int stop_at;
        write_palette(pal);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at      = item_count + n_items;
        while (item_count < stop_at) begin
            choice = $urandom_range(99);
            if (choice < 12) begin
                if ($urandom_range(7) == 0)
                    addr = $urandom_range(16383);
                else
                    addr = $urandom_range(19) + $urandom_range(17) * MAP_WIDTH_DEF;
                val = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(31);
                write_item(KIND_MAP, addr, val);
            end else if (choice < 20) begin
                addr = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(31);
                write_item(KIND_REMAP, addr, int'(pick_tile()));
            end else if (choice < 32) begin
                addr = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(255);
                write_item(KIND_PIXELS, addr, $urandom_range(1023));
            end else if (choice < 40) begin
                if ($urandom_range(1) == 0)
                    render_pixel($urandom_range(255, SCREEN_WIDTH_DEF), $urandom_range(255));
                else
                    render_pixel($urandom_range(255), $urandom_range(255, SCREEN_HEIGHT_DEF));
            end else begin
                render_pixel($urandom_range(SCREEN_WIDTH_DEF - 1),
                             $urandom_range(SCREEN_HEIGHT_DEF - 1));
            end
        end
    endtask

    always @(posedge clk)
        res_if.ready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);

    // result checker
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (shade_queue.size() == 0) begin
                $error("unexpected result: shade %0d pix_code %0d",
                       res_if.shade, res_if.pix_code);
                fail_count++;
            end else begin
                want = shade_queue.pop_front();
                if (res_if.shade !== want.shade) begin
                    $error("shade: expected %0d, actual %0d", want.shade, res_if.shade);
                    fail_count++;
                end
                if (res_if.pix_code !== want.pix_code) begin
                    $error("pix_code: expected %0d, actual %0d",
                           want.pix_code, res_if.pix_code);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.kind    = KIND_MAP;
        req_if.address = '0;
        req_if.value   = '0;
        req_if.pixel_x = '0;
        req_if.pixel_y = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.palette = '0;
        res_if.ready   = 1'b0;
        palette_mirror = PALETTE_RESET;
        src_idle_pct   = 23;
        snk_idle_pct   = 62;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_palette();
        test_store_limits();
        test_palette_extremes();
        test_random_traffic(190, 23, 62, 8'h1B);
        test_random_traffic(190, 62, 23, PAL_W'($urandom));
        test_random_traffic(190, 0, 0, PALETTE_RESET);
        wait_idle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
